@@ hw/rtl/countdown_timer_with_presets_defines.svh @@
// Assertion macros used by the checker file of the countdown timer.
`ifndef COUNTDOWN_TIMER_WITH_PRESETS_DEFINES_SVH
`define COUNTDOWN_TIMER_WITH_PRESETS_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define CT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define CT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/ctwp_pkg.sv @@
package ctwp_pkg;

	// Preset slots and field widths
	localparam int NUM_SLOTS   = 5;
	localparam int SLOT_W      = 3;
	localparam int SLOT_IDX_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int HOURS_W     = 5;
	localparam int MIN_W       = 6;
	localparam int SEC_W       = 6;
	localparam int KEY_W       = 3;
	localparam int ENTRY_W     = HOURS_W + MIN_W + SEC_W;
	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 32;
	localparam int OUT_USED_W  = 26;

	localparam logic [SLOT_W-1:0]  SLOT_LAST  = SLOT_W'(NUM_SLOTS - 1);
	localparam logic [HOURS_W-1:0] HOURS_MAX  = 5'd23;
	localparam logic [MIN_W-1:0]   MINSEC_MAX = 6'd59;

	// Key codes
	localparam logic [KEY_W-1:0] KEY_SLOT = 3'd1;
	localparam logic [KEY_W-1:0] KEY_EDIT = 3'd2;
	localparam logic [KEY_W-1:0] KEY_INC  = 3'd3;
	localparam logic [KEY_W-1:0] KEY_RUN  = 3'd4;

	typedef enum logic [1:0] {
		MODE_STANDBY = 2'd0,
		MODE_SETTING = 2'd1,
		MODE_RUNNING = 2'd2,
		MODE_PAUSE   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		REQ_KEY        = 2'd0,
		REQ_SEC_TICK   = 2'd1,
		REQ_BLINK_TICK = 2'd2
	} req_type_t;

	typedef enum logic [1:0] {
		FIELD_NONE    = 2'd0,
		FIELD_HOURS   = 2'd1,
		FIELD_MINUTES = 2'd2,
		FIELD_SECONDS = 2'd3
	} field_t;

	typedef struct packed {
		req_type_t        req_type;
		logic [KEY_W-1:0] key_code;
		logic             long_press;
	} req_t;

	typedef struct packed {
		logic [HOURS_W-1:0] hours;
		logic [MIN_W-1:0]   minutes;
		logic [SEC_W-1:0]   seconds;
		mode_t              mode;
		field_t             edit_field;
		logic [SLOT_W-1:0]  slot;
		logic               drive_active;
		logic               lamp_on;
	} res_t;

endpackage

@@ hw/rtl/ctwp_in_reg.sv @@
module ctwp_in_reg
	import ctwp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_TDATA_W-1:0] s_tdata,  // [2:0] key_code, [3] long_press, [7:4] zero
	input  logic [1:0]            s_tuser,  // [1:0] req_type
	input  logic                  advance,
	output logic                  valid,
	output req_t                  req
);

	logic valid_s1;
	req_t req_s1;
	logic accept;

	// Take a new item when the stage is empty or moves on this cycle
	assign s_tready = !valid_s1 || advance;
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && !advance);
		end
	end

	// Capture the item fields
	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1.req_type   <= req_type_t'(s_tuser);
			req_s1.key_code   <= s_tdata[KEY_W-1:0];
			req_s1.long_press <= s_tdata[KEY_W];
		end
	end

	assign valid = valid_s1;
	assign req   = req_s1;

endmodule

@@ hw/rtl/ctwp_core.sv @@
module ctwp_core
	import ctwp_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic fire,
	input  req_t req,
	output res_t res
);

	logic [HOURS_W-1:0] hours_q, hours_d;
	logic [MIN_W-1:0]   minutes_q, minutes_d;
	logic [SEC_W-1:0]   seconds_q, seconds_d;
	mode_t              mode_q, mode_d;
	field_t             field_q, field_d;
	logic [SLOT_W-1:0]  slot_q, slot_d;
	logic               blink_q, blink_d;
	logic [ENTRY_W-1:0] store_q [NUM_SLOTS];
	logic               store_wr;

	logic [SLOT_W-1:0]  slot_inc;
	logic [ENTRY_W-1:0] load_entry;
	field_t             field_inc;
	logic [HOURS_W-1:0] hours_inc, hours_dec;
	logic [MIN_W-1:0]   minutes_inc, minutes_dec;
	logic [SEC_W-1:0]   seconds_inc, seconds_dec;
	logic               is_zero;

	// Slot advance and the preset it selects
	assign slot_inc   = (slot_q >= SLOT_LAST) ? '0 : slot_q + SLOT_W'(1);
	assign load_entry = store_q[slot_inc[SLOT_IDX_W-1:0]];
	assign field_inc  = (field_q == FIELD_SECONDS) ? FIELD_HOURS : field_t'(field_q + 2'd1);

	// Field increments with wrap
	assign hours_inc   = (hours_q >= HOURS_MAX) ? '0 : hours_q + HOURS_W'(1);
	assign minutes_inc = (minutes_q >= MINSEC_MAX) ? '0 : minutes_q + MIN_W'(1);
	assign seconds_inc = (seconds_q >= MINSEC_MAX) ? '0 : seconds_q + SEC_W'(1);

	// Count down by one second, hold at zero
	assign is_zero = (hours_q == '0) && (minutes_q == '0) && (seconds_q == '0);

	always_comb begin
		hours_dec   = hours_q;
		minutes_dec = minutes_q;
		seconds_dec = seconds_q;
		if (is_zero) begin
			seconds_dec = '0;
		end else if (seconds_q != '0) begin
			seconds_dec = seconds_q - SEC_W'(1);
		end else if (minutes_q != '0) begin
			minutes_dec = minutes_q - MIN_W'(1);
			seconds_dec = MINSEC_MAX;
		end else begin
			hours_dec   = hours_q - HOURS_W'(1);
			minutes_dec = MINSEC_MAX;
			seconds_dec = MINSEC_MAX;
		end
	end

	// Next state for one item
	always_comb begin
		hours_d   = hours_q;
		minutes_d = minutes_q;
		seconds_d = seconds_q;
		mode_d    = mode_q;
		field_d   = field_q;
		slot_d    = slot_q;
		blink_d   = blink_q;
		store_wr  = 1'b0;
		case (req.req_type)
			REQ_KEY: begin
				if (!req.long_press) begin
					case (req.key_code)
						KEY_SLOT: begin
							if (mode_q == MODE_STANDBY) begin
								slot_d    = slot_inc;
								hours_d   = load_entry[ENTRY_W-1 -: HOURS_W];
								minutes_d = load_entry[SEC_W +: MIN_W];
								seconds_d = load_entry[SEC_W-1:0];
							end
						end
						KEY_EDIT: begin
							mode_d  = MODE_SETTING;
							field_d = field_inc;
						end
						KEY_INC: begin
							if (mode_q == MODE_SETTING) begin
								if (field_q == FIELD_HOURS) hours_d = hours_inc;
								if (field_q == FIELD_MINUTES) minutes_d = minutes_inc;
								if (field_q == FIELD_SECONDS) seconds_d = seconds_inc;
							end
						end
						KEY_RUN: begin
							case (mode_q)
								MODE_STANDBY: mode_d = MODE_RUNNING;
								MODE_RUNNING: mode_d = MODE_PAUSE;
								MODE_PAUSE:   mode_d = MODE_RUNNING;
								MODE_SETTING: begin
									mode_d  = MODE_RUNNING;
									field_d = FIELD_NONE;
								end
								default: mode_d = mode_q;
							endcase
						end
						default: ;
					endcase
				end else begin
					case (req.key_code)
						KEY_EDIT: begin
							store_wr = 1'b1;
							mode_d   = MODE_STANDBY;
							field_d  = FIELD_NONE;
						end
						KEY_INC: begin
							if (mode_q == MODE_SETTING) begin
								if (field_q == FIELD_HOURS) hours_d = hours_inc;
								if (field_q == FIELD_MINUTES) minutes_d = minutes_inc;
								if (field_q == FIELD_SECONDS) seconds_d = seconds_inc;
							end
						end
						KEY_RUN: begin
							if (mode_q == MODE_RUNNING || mode_q == MODE_PAUSE) begin
								mode_d = MODE_STANDBY;
							end
						end
						default: ;
					endcase
				end
			end
			REQ_SEC_TICK: begin
				if (mode_q == MODE_RUNNING) begin
					hours_d   = hours_dec;
					minutes_d = minutes_dec;
					seconds_d = seconds_dec;
				end
			end
			REQ_BLINK_TICK: begin
				if (mode_q == MODE_RUNNING) blink_d = !blink_q;
			end
			default: ;
		endcase
	end

	// Result shows the state after the update
	always_comb begin
		res.hours        = hours_d;
		res.minutes      = minutes_d;
		res.seconds      = seconds_d;
		res.mode         = mode_d;
		res.edit_field   = field_d;
		res.slot         = slot_d;
		res.drive_active = (mode_d == MODE_RUNNING);
		res.lamp_on      = (mode_d == MODE_RUNNING) && blink_d;
	end

	// Hold timer state, advance on each item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hours_q   <= '0;
			minutes_q <= '0;
			seconds_q <= '0;
			mode_q    <= MODE_STANDBY;
			field_q   <= FIELD_NONE;
			slot_q    <= '0;
			blink_q   <= 1'b0;
		end else if (fire) begin
			hours_q   <= hours_d;
			minutes_q <= minutes_d;
			seconds_q <= seconds_d;
			mode_q    <= mode_d;
			field_q   <= field_d;
			slot_q    <= slot_d;
			blink_q   <= blink_d;
		end
	end

	// Save the current time into the selected preset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				store_q[i] <= '0;
			end
		end else begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				if (fire && store_wr && (slot_q == SLOT_W'(i))) begin
					store_q[i] <= {hours_q, minutes_q, seconds_q};
				end
			end
		end
	end

endmodule

@@ hw/rtl/ctwp_out_reg.sv @@
module ctwp_out_reg
	import ctwp_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   load,
	input  res_t                   res,
	output logic                   ready,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata
);

	logic valid_s2;
	res_t res_s2;

	// Room for a new result when empty or the held one leaves now
	assign ready = !valid_s2 || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_s2 <= res;
		end
	end

	// Pack result fields, lowest first
	assign m_tvalid = valid_s2;
	assign m_tdata  = {
		(OUT_TDATA_W - OUT_USED_W)'(0),
		res_s2.lamp_on,
		res_s2.drive_active,
		res_s2.slot,
		res_s2.edit_field,
		res_s2.mode,
		res_s2.seconds,
		res_s2.minutes,
		res_s2.hours
	};

endmodule

@@ hw/rtl/countdown_timer_with_presets.sv @@
// Countdown timer with presets: one result item for every input item.
// An accepted item is held in the input register until the output register has
// room, then its result is loaded there and offered on m_tdata.
// Throughput: one item per cycle while m_tready does not stall the output register.
// Reset (arst_n low, asynchronous): time, mode, edit field, slot, blink phase
// and all preset slots clear to zero; no clearing pass is needed.
module countdown_timer_with_presets
	import ctwp_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,  // [2:0] key_code, [3] long_press, [7:4] zero
	input  logic [1:0]             s_tuser,  // [1:0] req_type
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata   // [4:0] hours, [10:5] minutes, [16:11] seconds,
	                                         // [18:17] mode, [20:19] edit_field, [23:21] slot,
	                                         // [24] drive_active, [25] lamp_on, [31:26] zero
);

	logic valid_s1;
	req_t req_s1;
	res_t res;
	logic out_ready;
	logic fire;

	// Move the held item into the result register when there is room
	assign fire = valid_s1 && out_ready;

	ctwp_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.advance  (fire),
		.valid    (valid_s1),
		.req      (req_s1)
	);

	ctwp_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.req    (req_s1),
		.res    (res)
	);

	ctwp_out_reg u_out_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (fire),
		.res      (res),
		.ready    (out_ready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

@@ hw/rtl/ctwp_checker.sv @@
`include "countdown_timer_with_presets_defines.svh"

module ctwp_checker
	import ctwp_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata
);

	// Stalled result holds
	`CT_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")

	// Drive follows the running mode
	`CT_ASSERT_NOW(a_drive_mode, m_tvalid, m_tdata[24] == (m_tdata[18:17] == MODE_RUNNING), "drive_active does not match mode")

	// Lamp lights only while running
	`CT_ASSERT_NOW(a_lamp_run, m_tvalid && m_tdata[25], m_tdata[24], "lamp on outside running")

	// Time fields stay in range
	`CT_ASSERT_NOW(a_time_range, m_tvalid, (m_tdata[4:0] <= HOURS_MAX) && (m_tdata[10:5] <= MINSEC_MAX) && (m_tdata[16:11] <= MINSEC_MAX), "time field out of range")

	// Slot stays below the slot count
	`CT_ASSERT_NOW(a_slot_range, m_tvalid, m_tdata[23:21] <= SLOT_LAST, "slot out of range")

endmodule

bind countdown_timer_with_presets ctwp_checker u_checker (.*);

@@ tb/tb_countdown_timer_with_presets.sv @@
module tb_countdown_timer_with_presets;
	timeunit 1ns;
	timeprecision 1ps;

	import ctwp_pkg::*;

	localparam int SECS_PER_HOUR = 3600;
	localparam int SECS_PER_MIN  = 60;
	localparam int RANDOM_ITEMS  = 1500;
	localparam int LONG_HOLD     = 300;

	// Tracks the timer state, predicts each status item and checks the DUT output
	class timer_tracker;
		logic [HOURS_W-1:0] hrs;
		logic [MIN_W-1:0]   mins;
		logic [SEC_W-1:0]   secs;
		mode_t              mode;
		field_t             field;
		logic [SLOT_W-1:0]  slot;
		logic               blink;
		logic [ENTRY_W-1:0] presets [NUM_SLOTS];
		res_t               expected_status [$];
		int                 errors;

		function new();
			hrs    = '0;
			mins   = '0;
			secs   = '0;
			mode   = MODE_STANDBY;
			field  = FIELD_NONE;
			slot   = '0;
			blink  = 1'b0;
			errors = 0;
			foreach (presets[i]) presets[i] = '0;
		endfunction

		function int pending();
			return expected_status.size();
		endfunction

		// Apply one accepted request and queue the status it must produce
		function void note_request(logic [1:0] kind, logic [KEY_W-1:0] key, logic long_press);
			res_t st;
			int   total;
			int   idx;
			idx = (int'(slot) < NUM_SLOTS) ? int'(slot) : 0;
			if (kind == REQ_KEY) begin
				if (key == KEY_INC) begin
					// Increment works alike for short and long presses, only while setting
					if (mode == MODE_SETTING) begin
						case (field)
							FIELD_HOURS:   hrs  = (hrs >= HOURS_MAX) ? '0 : hrs + 1'b1;
							FIELD_MINUTES: mins = (mins >= MINSEC_MAX) ? '0 : mins + 1'b1;
							FIELD_SECONDS: secs = (secs >= MINSEC_MAX) ? '0 : secs + 1'b1;
							default: ;
						endcase
					end
				end else if (!long_press) begin
					case (key)
						KEY_SLOT: begin
							if (mode == MODE_STANDBY) begin
								slot = (int'(slot) + 1 >= NUM_SLOTS) ? '0 : slot + 1'b1;
								idx  = (int'(slot) < NUM_SLOTS) ? int'(slot) : 0;
								{hrs, mins, secs} = presets[idx];
							end
						end
						KEY_EDIT: begin
							mode  = MODE_SETTING;
							field = (field == FIELD_SECONDS) ? FIELD_HOURS : field_t'(field + 1'b1);
						end
						KEY_RUN: begin
							if (mode == MODE_RUNNING) begin
								mode = MODE_PAUSE;
							end else begin
								if (mode == MODE_SETTING) field = FIELD_NONE;
								mode = MODE_RUNNING;
							end
						end
						default: ;
					endcase
				end else begin
					case (key)
						KEY_EDIT: begin
							presets[idx] = {hrs, mins, secs};
							mode         = MODE_STANDBY;
							field        = FIELD_NONE;
						end
						KEY_RUN: begin
							if (mode == MODE_RUNNING || mode == MODE_PAUSE) mode = MODE_STANDBY;
						end
						default: ;
					endcase
				end
			end else if (kind == REQ_SEC_TICK) begin
				// Count down one second, hold at zero
				if (mode == MODE_RUNNING) begin
					total = int'(hrs) * SECS_PER_HOUR + int'(mins) * SECS_PER_MIN + int'(secs);
					if (total > 0) total--;
					hrs  = HOURS_W'(total / SECS_PER_HOUR);
					mins = MIN_W'((total % SECS_PER_HOUR) / SECS_PER_MIN);
					secs = SEC_W'((total % SECS_PER_HOUR) % SECS_PER_MIN);
				end
			end else if (kind == REQ_BLINK_TICK) begin
				if (mode == MODE_RUNNING) blink = ~blink;
			end

			st.hours        = hrs;
			st.minutes      = mins;
			st.seconds      = secs;
			st.mode         = mode;
			st.edit_field   = field;
			st.slot         = slot;
			st.drive_active = (mode == MODE_RUNNING);
			st.lamp_on      = (mode == MODE_RUNNING) && blink;
			expected_status.push_back(st);
		endfunction

		function void compare(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				$error("%s: expected %0d, actual %0d", name, want, got);
				errors++;
			end
		endfunction

		// Match one output item against the oldest predicted status
		function void check_status(logic [OUT_TDATA_W-1:0] raw);
			res_t st;
			if (expected_status.size() == 0) begin
				$error("status item 0x%08h arrived with nothing pending", raw);
				errors++;
				return;
			end
			st = expected_status.pop_front();
			compare("hours",        st.hours,        raw[4:0]);
			compare("minutes",      st.minutes,      raw[10:5]);
			compare("seconds",      st.seconds,      raw[16:11]);
			compare("mode",         st.mode,         raw[18:17]);
			compare("edit_field",   st.edit_field,   raw[20:19]);
			compare("slot",         st.slot,         raw[23:21]);
			compare("drive_active", st.drive_active, raw[24]);
			compare("lamp_on",      st.lamp_on,      raw[25]);
			compare("padding",      0,               raw[OUT_TDATA_W-1:OUT_USED_W]);
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;   // [2:0] key_code, [3] long_press, [7:4] zero
	logic [1:0]             s_tuser;   // [1:0] req_type
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;   // [4:0] hours, [10:5] minutes, [16:11] seconds,
	                                   // [18:17] mode, [20:19] edit_field, [23:21] slot,
	                                   // [24] drive_active, [25] lamp_on, [31:26] zero

	timer_tracker tracker = new();
	int           rx_hold   = 0;
	int           burst_left = 0;
	int           stim_count = 0;

	countdown_timer_with_presets DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Give up after a generous fixed time
	initial begin
		#3_000_000;
		$display("** countdown_timer_with_presets: FAILED **");
		$finish;
	end

	// Sample both handshakes at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				tracker.note_request(s_tuser, s_tdata[KEY_W-1:0], s_tdata[KEY_W]);
			end
			if (m_tvalid && m_tready) begin
				tracker.check_status(m_tdata);
			end
		end
	end

	// Receiver: stall in segments of varying style, hold off fully on request
	initial begin
		int seg;
		int style;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			seg   = $urandom_range(8, 64);
			style = $urandom_range(0, 2);
			repeat (seg) begin
				@(negedge clk);
				if (rx_hold > 0) begin
					m_tready <= 1'b0;
					rx_hold--;
				end else begin
					case (style)
						0:       m_tready <= 1'b1;
						1:       m_tready <= 1'($urandom_range(0, 1));
						default: m_tready <= ($urandom_range(0, 3) == 0);
					endcase
				end
			end
		end
	end

	// Offer one item, with bursts and gaps, and hold it until accepted
	task automatic send_req(logic [1:0] kind, logic [KEY_W-1:0] key, logic long_press);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				@(negedge clk);
				s_tvalid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {{(IN_TDATA_W-KEY_W-1){1'b0}}, long_press, key};
		do @(posedge clk); while (!s_tready);
		stim_count++;
	endtask

	task automatic press(logic [KEY_W-1:0] key, logic long_press);
		send_req(REQ_KEY, key, long_press);
	endtask

	// Drop valid and wait until every predicted status has come back
	task automatic wait_drained();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
	endtask

	initial begin
		int  r;
		int  n;
		bit  drained_once;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		s_tuser      = '0;
		arst_n       = 1'b0;
		drained_once = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: countdown held at zero, ignored ticks and keys, edit cycle, pause/resume
		press(KEY_RUN, 1'b0);
		send_req(REQ_SEC_TICK, '0, 1'b0);
		send_req(REQ_BLINK_TICK, '0, 1'b0);
		press(KEY_RUN, 1'b1);
		send_req(REQ_BLINK_TICK, '0, 1'b0);
		send_req(REQ_SEC_TICK, '0, 1'b0);
		send_req(2'd3, 3'd7, 1'b1);
		press(3'd0, 1'b0);
		press(3'd7, 1'b1);
		press(3'd5, 1'b0);
		press(KEY_SLOT, 1'b1);
		press(KEY_INC, 1'b0);
		press(KEY_RUN, 1'b1);
		press(KEY_EDIT, 1'b0);
		press(KEY_INC, 1'b0);
		press(KEY_EDIT, 1'b0);
		press(KEY_INC, 1'b1);
		press(KEY_EDIT, 1'b0);
		press(KEY_EDIT, 1'b0);
		press(KEY_RUN, 1'b0);
		send_req(REQ_SEC_TICK, '0, 1'b0);
		send_req(REQ_BLINK_TICK, '0, 1'b0);
		press(KEY_RUN, 1'b0);
		send_req(REQ_SEC_TICK, '0, 1'b0);
		press(KEY_RUN, 1'b0);
		press(KEY_EDIT, 1'b1);
		press(KEY_SLOT, 1'b0);

		// Random: mostly well-formed key sequences, some noise
		stim_count = 0;
		rx_hold    = LONG_HOLD;
		while (stim_count < RANDOM_ITEMS) begin
			if (!drained_once && stim_count >= RANDOM_ITEMS / 2) begin
				wait_drained();
				drained_once = 1'b1;
			end
			r = $urandom_range(0, 99);
			if (r < 20) begin
				// Edit: pick a field, then increment it, sometimes past the wrap
				repeat ($urandom_range(1, 3)) press(KEY_EDIT, 1'b0);
				n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 70) : $urandom_range(1, 30);
				repeat (n) press(KEY_INC, 1'($urandom_range(0, 1)));
				if ($urandom_range(0, 1)) press(KEY_EDIT, 1'b1);
				else press(KEY_RUN, 1'b0);
			end else if (r < 35) begin
				// Walk through the preset slots, sometimes going to standby first
				if ($urandom_range(0, 1)) press(KEY_EDIT, 1'b1);
				repeat ($urandom_range(1, 6)) press(KEY_SLOT, 1'b0);
			end else if (r < 70) begin
				// Run: ticks with the odd pause or resume, then maybe stop
				press(KEY_RUN, 1'b0);
				repeat ($urandom_range(1, 60)) begin
					n = $urandom_range(0, 99);
					if (n < 70) send_req(REQ_SEC_TICK, KEY_W'($urandom_range(0, 7)), 1'b0);
					else if (n < 95) send_req(REQ_BLINK_TICK, '0, 1'($urandom_range(0, 1)));
					else press(KEY_RUN, 1'b0);
				end
				if ($urandom_range(0, 9) < 4) press(KEY_RUN, 1'b1);
			end else if (r < 85) begin
				press(KEY_EDIT, 1'b1);
			end else begin
				// Noise: any request type, any key code
				n = $urandom_range(1, 5);
				repeat (n) begin
					send_req(2'($urandom_range(0, 3)), KEY_W'($urandom_range(0, 7)),
						1'($urandom_range(0, 1)));
				end
				stim_count -= n;
			end
		end

		wait_drained();
		repeat (10) @(posedge clk);
		if (tracker.errors == 0) begin
			$display("** countdown_timer_with_presets: PASSED **");
		end else begin
			$display("** countdown_timer_with_presets: FAILED **");
		end
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/ctwp_pkg.sv
hw/rtl/ctwp_in_reg.sv
hw/rtl/ctwp_core.sv
hw/rtl/ctwp_out_reg.sv
hw/rtl/countdown_timer_with_presets.sv
hw/rtl/ctwp_checker.sv
tb/tb_countdown_timer_with_presets.sv
